@@ rtl/ipc_pkg.sv @@
// Package for the intersection phase controller.
// Holds the payload and configuration types, codes and sizing constants.
// Depends on nothing; every other file in rtl imports it.
package ipc_pkg;

	// Width of one waiting-car counter.
	localparam int COUNT_BITS = 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Lane limit handling.
	localparam logic [7:0] LIMIT_RESET  = 8'd20;
	localparam logic [7:0] LIMIT_TOP    = 8'd200;
	localparam int         LIMIT_MARGIN = 3;

	// Fixed-mode dwell: the phase toggles once the tick count passes this.
	localparam logic [7:0] FIXED_DWELL = 8'd9;
	localparam logic [7:0] DWELL_MAX   = 8'd255;

	// Released counts are reported in eight bits and saturate.
	localparam int REL_BITS = 8;

	localparam int NUM_LANES = 4;
	localparam int NUM_QUEUES = 2 * NUM_LANES;

	// Operation codes.
	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Direction codes.
	localparam logic DIR_LEFT     = 1'b0;
	localparam logic DIR_STRAIGHT = 1'b1;

	// Drain modes.
	localparam logic MODE_ONE_CAR = 1'b0;
	localparam logic MODE_DRAIN   = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LANE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DRAIN_MODE = 2'd1;

	typedef struct packed {
		logic       op;
		logic [1:0] lane;
		logic       turn;
	} in_item_t;

	typedef struct packed {
		logic                detoured;
		logic                phase_served;
		logic [REL_BITS-1:0] first_released;
		logic                first_turn;
		logic [REL_BITS-1:0] second_released;
		logic                second_turn;
		logic                phase_switched;
		logic [31:0]         arrivals_total;
		logic [31:0]         detours_total;
	} out_item_t;

	typedef struct packed {
		logic [7:0] lane_limit;
		logic       drain_mode;
	} cfg_t;

endpackage

@@ rtl/ipc_cfg.sv @@
// Configuration register file of the intersection phase controller.
// Depends on ipc_pkg for the register indexes and the cfg_t bundle.
module ipc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [7:0]                        cfg_data,
	output ipc_pkg::cfg_t                     cfg
);
	import ipc_pkg::*;

	logic [7:0] lane_limit_q;
	logic       drain_mode_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// A limit above the top of the range falls back to the reset limit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_limit_q <= LIMIT_RESET;
			drain_mode_q <= MODE_ONE_CAR;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LANE_LIMIT: begin
					lane_limit_q <= (cfg_data > LIMIT_TOP) ? LIMIT_RESET : cfg_data;
				end
				REG_DRAIN_MODE: begin
					drain_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.lane_limit = lane_limit_q;
	assign cfg.drain_mode = drain_mode_q;

endmodule

@@ rtl/ipc_core.sv @@
// Queue state and single-pass update logic of the intersection phase controller.
// Depends on ipc_pkg; the caller supplies the registered request and the enable.
module ipc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  ipc_pkg::in_item_t  item,
	input  ipc_pkg::cfg_t      cfg,
	output ipc_pkg::out_item_t result
);
	import ipc_pkg::*;

	logic [COUNT_BITS-1:0] queue_q [NUM_QUEUES];
	logic [COUNT_BITS-1:0] queue_d [NUM_QUEUES];
	logic                  phase_q;
	logic [7:0]            dwell_q;
	logic [31:0]           arrivals_q;
	logic [31:0]           detours_q;

	logic                  lane_full [NUM_LANES];
	logic                  lane_busy [NUM_LANES];
	logic                  lane_dir  [NUM_LANES];
	logic [COUNT_BITS-1:0] lane_rel  [NUM_LANES];
	logic [REL_BITS-1:0]   lane_rel8 [NUM_LANES];

	logic        is_tick;
	logic        full_sel;
	logic        detour;
	logic [31:0] arrivals_d;
	logic [31:0] detours_d;
	logic [7:0]  dwell_inc;
	logic        busy_first;
	logic        busy_second;
	logic        toggle;
	logic [8:0]  dwell_margin;

	assign is_tick = (item.op == OP_TICK);

	// Per-lane admission check and service choice; each lane looks only at its own pair.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			lane_full[l] = ({2'b00, queue_q[2*l]} + {2'b00, queue_q[2*l+1]}
				+ (COUNT_BITS+2)'(LIMIT_MARGIN)) > (COUNT_BITS+2)'(cfg.lane_limit);
			lane_dir[l]  = (queue_q[2*l+1] != '0);
			lane_busy[l] = lane_dir[l] || (queue_q[2*l] != '0);
			if (!lane_busy[l]) begin
				lane_rel[l] = '0;
			end else if (cfg.drain_mode == MODE_DRAIN) begin
				lane_rel[l] = lane_dir[l] ? queue_q[2*l+1] : queue_q[2*l];
			end else begin
				lane_rel[l] = COUNT_BITS'(1);
			end
			if (lane_rel[l] > COUNT_BITS'(2**REL_BITS - 1)) begin
				lane_rel8[l] = {REL_BITS{1'b1}};
			end else begin
				lane_rel8[l] = REL_BITS'(lane_rel[l]);
			end
		end
	end

	// Arrival admission and running tallies.
	assign full_sel   = lane_full[item.lane];
	assign detour     = !is_tick && full_sel;
	assign arrivals_d = is_tick ? arrivals_q : arrivals_q + 32'd1;
	assign detours_d  = detour ? detours_q + 32'd1 : detours_q;

	// Phase timing.
	assign busy_first   = phase_q ? lane_busy[2] : lane_busy[0];
	assign busy_second  = phase_q ? lane_busy[3] : lane_busy[1];
	assign dwell_inc    = (dwell_q == DWELL_MAX) ? DWELL_MAX : dwell_q + 8'd1;
	assign dwell_margin = {1'b0, dwell_inc} + 9'(LIMIT_MARGIN);

	always_comb begin
		if (cfg.drain_mode == MODE_ONE_CAR) begin
			toggle = dwell_inc > FIXED_DWELL;
		end else begin
			toggle = busy_first || busy_second || (dwell_margin > {1'b0, cfg.lane_limit});
		end
	end

	// Next value of each counter: served on a tick of its phase, filled on an admitted arrival.
	always_comb begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			queue_d[q] = queue_q[q];
			if (is_tick) begin
				if (((q / 2) >> 1) == int'(phase_q)) begin
					if (((q % 2) == 1 && queue_q[q] != '0)
						|| ((q % 2) == 0 && queue_q[q | 1] == '0 && queue_q[q] != '0)) begin
						queue_d[q] = (cfg.drain_mode == MODE_DRAIN) ? '0
							: queue_q[q] - COUNT_BITS'(1);
					end
				end
			end else if (!full_sel && q == int'({item.lane, item.turn})
				&& queue_q[q] != COUNT_MAX) begin
				queue_d[q] = queue_q[q] + COUNT_BITS'(1);
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				queue_q[q] <= '0;
			end
			phase_q    <= 1'b0;
			dwell_q    <= '0;
			arrivals_q <= '0;
			detours_q  <= '0;
		end else if (fire) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				queue_q[q] <= queue_d[q];
			end
			arrivals_q <= arrivals_d;
			detours_q  <= detours_d;
			if (is_tick) begin
				if (toggle) begin
					dwell_q <= '0;
					phase_q <= ~phase_q;
				end else begin
					dwell_q <= dwell_inc;
				end
			end
		end
	end

	// Result assembly.
	always_comb begin
		result                 = '0;
		result.detoured        = detour;
		result.phase_served    = phase_q;
		result.arrivals_total  = arrivals_d;
		result.detours_total   = detours_d;
		if (is_tick) begin
			result.first_released  = phase_q ? lane_rel8[2] : lane_rel8[0];
			result.first_turn      = phase_q ? lane_dir[2] : lane_dir[0];
			result.second_released = phase_q ? lane_rel8[3] : lane_rel8[1];
			result.second_turn     = phase_q ? lane_dir[3] : lane_dir[1];
			result.phase_switched  = toggle;
		end
	end

endmodule

@@ rtl/intersection_phase_controller.sv @@
// Intersection phase controller: one request in, one result out, one request per cycle
// while item_stall is low. A request enters an input register, its result is formed by
// ipc_core from that register and held in an output register, where result_valid marks
// it valid. A new request is taken every cycle while results are drained. Configuration
// writes (lane limit, drain mode) are always ready and must be made while the block is idle.
// Depends on ipc_pkg, ipc_cfg and ipc_core.
module intersection_phase_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  ipc_pkg::in_item_t                item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output ipc_pkg::out_item_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ipc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [7:0]                       cfg_data
);
	import ipc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t core_result;
	cfg_t      cfg;
	logic      advance;
	logic      take;

	ipc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 moves to the output register when that register is free or being read.
	assign advance    = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	ipc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= core_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
